// ----- rtl/core/albs_pkg.sv -----
// Shared types, constants and the level clamp for the ambient light backlight slew core.
// No dependencies.
`default_nettype none

package albs_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Q2.10 sample times Q8.8 gain carries 18 fraction bits
    localparam int FRAC_SHIFT = 18;

    // Reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd19341;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd15;
    localparam logic [LEVEL_W-1:0] MIN_RESET   = 8'd50;
    localparam logic [LEVEL_W-1:0] MAX_RESET   = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 2'd0,
        CFG_STEP = 2'd1,
        CFG_MIN  = 2'd2,
        CFG_MAX  = 2'd3
    } t_cfg_idx;

    // Clamp to max first, then to min, so min wins when the limits cross
    function automatic logic [LEVEL_W-1:0] limit_level(
        input logic signed [LEVEL_W+1:0] v,
        input logic [LEVEL_W-1:0]        lo,
        input logic [LEVEL_W-1:0]        hi
    );
        logic signed [LEVEL_W+1:0] t;
        t = v;
        if (t > $signed({2'b00, hi})) begin
            t = $signed({2'b00, hi});
        end
        if (t < $signed({2'b00, lo})) begin
            t = $signed({2'b00, lo});
        end
        return t[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ambient_light_backlight_slew_core.sv -----
// Top level: moving average of light samples and slew-limited backlight level.
// Depends on albs_pkg and albs_ram.
`default_nettype none

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_kind, i_light_sample
//  out     | output    | o_out_valid / i_out_stall | o_level, o_target_level
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A sample word passes these steps from acceptance to result: one sum update (the window
//  RAM read lands at acceptance), one gain multiply, one reciprocal multiply on the same
//  shared multiplier for the divide by WINDOW, one clamp, then the output register.
//  A tick word passes slew and clamp, then the output register.
//  Synchronous active-low reset clears the window valid bits and sum and loads the
//  reset values into the levels and config. o_in_stall is high while a word is in work,
//  so a new word is taken the cycle after a result is loaded. A stalled result holds
//  the block in its output step until taken. o_cfg_ready is always high.

module ambient_light_backlight_slew_core
    import albs_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [SAMPLE_W-1:0]   i_light_sample,
    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [LEVEL_W-1:0]    o_level,
    output logic      [LEVEL_W-1:0]    o_target_level,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int QW      = SUM_W + GAIN_W - FRAC_SHIFT;
    // Reciprocal of WINDOW, rounded up, exact for every QW-bit dividend
    localparam int RSH     = QW + $clog2(WINDOW);
    localparam int RECIP_W = QW + 1;
    localparam int OPB_W   = (GAIN_W > RECIP_W) ? GAIN_W : RECIP_W;
    localparam int MUL_W   = SUM_W + OPB_W;
    localparam int QH_W    = MUL_W - RSH;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [OPB_W-1:0]  RECIP     = OPB_W'(((1 << RSH) + WINDOW - 1) / WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_DONE,
        ST_TICK,
        ST_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [GAIN_W-1:0]  r_gain;
    logic [STEP_W-1:0]  r_step;
    logic [LEVEL_W-1:0] r_min;
    logic [LEVEL_W-1:0] r_max;

    // Window state
    logic [SAMPLE_W-1:0] r_sample;
    logic [SLOT_W-1:0]   r_slot;
    logic [WINDOW-1:0]   r_filled;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Divide state
    logic [QW-1:0]      r_scaled;
    logic [LEVEL_W-1:0] r_quo;
    logic               r_sat;

    // Levels
    logic [LEVEL_W-1:0] r_target;
    logic [LEVEL_W-1:0] r_level;

    // Combinational helpers
    logic [SAMPLE_W-1:0]      old_sample;
    logic [SUM_W-1:0]         n_sum;
    logic [SUM_W-1:0]         mul_a;
    logic [OPB_W-1:0]         mul_b;
    logic [MUL_W-1:0]         prod;
    logic [QH_W-1:0]          quo_hi;
    logic [LEVEL_W-1:0]       raw;
    logic [LEVEL_W-1:0]       tick_tgt;
    logic signed [LEVEL_W+1:0] cur;
    logic signed [LEVEL_W+1:0] tgt_s;
    logic signed [LEVEL_W+1:0] step_s;
    logic signed [LEVEL_W+1:0] n_cur;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    albs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_SUM),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    // Running sum: drop the oldest word, add the new one; unwritten slots read as zero
    always_comb begin
        old_sample = r_filled[r_slot] ? ram_rdata : '0;
        n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
    end

    // Shared multiplier: sum times gain, then scaled sum times the reciprocal of WINDOW
    always_comb begin
        if (r_state == ST_MUL) begin
            mul_a = r_sum;
            mul_b = OPB_W'(r_gain);
        end else begin
            mul_a = SUM_W'(r_scaled);
            mul_b = RECIP;
        end
        prod   = MUL_W'(mul_a) * MUL_W'(mul_b);
        quo_hi = prod[MUL_W-1:RSH];
        raw    = r_sat ? LEVEL_TOP : r_quo;
    end

    // Slew step toward the re-clamped target
    always_comb begin
        tick_tgt = limit_level($signed({2'b00, r_target}), r_min, r_max);
        cur      = $signed({2'b00, r_level});
        tgt_s    = $signed({2'b00, tick_tgt});
        step_s   = $signed({2'b00, r_step});
        if (cur < tgt_s) begin
            n_cur = cur + step_s;
        end else if (cur > tgt_s) begin
            n_cur = cur - step_s;
        end else begin
            n_cur = cur;
        end
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= GAIN_RESET;
            r_step      <= STEP_RESET;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_slot      <= '0;
            r_filled    <= '0;
            r_sum       <= '0;
            r_target    <= LEVEL_RESET;
            r_level     <= LEVEL_RESET;
            o_out_valid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN: r_gain <= i_cfg_data;
                    CFG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_MIN:  r_min  <= i_cfg_data[LEVEL_W-1:0];
                    CFG_MAX:  r_max  <= i_cfg_data[LEVEL_W-1:0];
                    default:  r_gain <= r_gain;
                endcase
            end

            // Drop a result once taken; the output step handles its own register
            if (o_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sample <= i_light_sample;
                        r_state  <= i_kind ? ST_TICK : ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sum            <= n_sum;
                    r_filled[r_slot] <= 1'b1;
                    r_slot           <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                    r_state          <= ST_MUL;
                end
                ST_MUL: begin
                    r_scaled <= prod[FRAC_SHIFT +: QW];
                    r_state  <= ST_DIV;
                end
                ST_DIV: begin
                    // Quotient past the level range saturates
                    r_quo   <= quo_hi[LEVEL_W-1:0];
                    r_sat   <= (quo_hi > QH_W'(LEVEL_TOP));
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_target <= limit_level($signed({2'b00, raw}), r_min, r_max);
                    r_state  <= ST_OUT;
                end
                ST_TICK: begin
                    r_target <= tick_tgt;
                    r_level  <= limit_level(n_cur, r_min, r_max);
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    // Advance once the output register is free
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid    <= 1'b1;
                        o_level        <= r_level;
                        o_target_level <= r_target;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/albs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module albs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
